// ----- sv/gcst_pkg.sv -----
// Shared constants, codes and types for the garbage-collector color side table.
`timescale 1ns / 1ps
package gcst_pkg;

	localparam int ADDR_W        = 48;
	localparam int COLOR_W       = 8;
	localparam int CFG_CNT_W     = 13;
	localparam int GRANULE_SHIFT = 12;
	localparam int TABLE_DEPTH   = 4096;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int USE_W         = IDX_W + 1;
	localparam int NUM_W         = (USE_W > CFG_CNT_W) ? USE_W : CFG_CNT_W;
	localparam int OFF_W         = ADDR_W - GRANULE_SHIFT;
	localparam int Q_DEPTH       = 4;
	localparam int Q_PTR_W       = $clog2(Q_DEPTH);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_FLIP  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic REG_HEAP_BASE   = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	localparam logic [CFG_CNT_W-1:0] ENTRY_COUNT_RESET = CFG_CNT_W'(4096);

	typedef struct packed {
		logic [1:0]         op;
		logic               in_range;
		logic [IDX_W-1:0]   idx;
		logic [USE_W-1:0]   count;
		logic [COLOR_W-1:0] color;
		logic [COLOR_W-1:0] match;
	} cmd_t;

endpackage

// ----- sv/gcst_front.sv -----
// Front end: address to granule index, range check, command build.
`timescale 1ns / 1ps
module gcst_front (
	input  logic [1:0]                     operation,
	input  logic [gcst_pkg::ADDR_W-1:0]    address,
	input  logic [gcst_pkg::COLOR_W-1:0]   color,
	input  logic [gcst_pkg::COLOR_W-1:0]   match_color,
	input  logic [gcst_pkg::ADDR_W-1:0]    heap_base,
	input  logic [gcst_pkg::CFG_CNT_W-1:0] entry_count,
	output logic                           keep,
	output gcst_pkg::cmd_t                 cmd
);

	logic [gcst_pkg::ADDR_W:0]    diff;
	logic [gcst_pkg::NUM_W-1:0]   cnt_ext;
	logic [gcst_pkg::NUM_W-1:0]   depth;
	logic [gcst_pkg::NUM_W-1:0]   n_sat;
	logic [gcst_pkg::USE_W-1:0]   n_use;
	logic [gcst_pkg::OFF_W-1:0]   offs;
	logic                         in_range;

	always_comb begin
		diff     = {1'b0, address} - {1'b0, heap_base};
		cnt_ext  = gcst_pkg::NUM_W'(entry_count);
		depth    = gcst_pkg::NUM_W'(gcst_pkg::TABLE_DEPTH);
		n_sat    = (cnt_ext > depth) ? depth : cnt_ext;
		n_use    = gcst_pkg::USE_W'(n_sat);
		offs     = diff[gcst_pkg::ADDR_W-1:gcst_pkg::GRANULE_SHIFT];
		// borrow out means address below base
		in_range = !diff[gcst_pkg::ADDR_W] && (offs < gcst_pkg::OFF_W'(n_use));

		cmd.op       = operation;
		cmd.in_range = in_range;
		cmd.idx      = offs[gcst_pkg::IDX_W-1:0];
		cmd.count    = n_use;
		cmd.color    = color;
		cmd.match    = match_color;

		unique case (operation)
			gcst_pkg::OP_LOAD:  keep = 1'b1;
			gcst_pkg::OP_STORE: keep = in_range;
			gcst_pkg::OP_FLIP:  keep = 1'b1;
			gcst_pkg::OP_NOP:   keep = 1'b0;
			default:            keep = 1'b0;
		endcase
	end

endmodule

// ----- sv/gcst_fifo.sv -----
// Short command queue between front end and table engine.
`timescale 1ns / 1ps
module gcst_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gcst_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output gcst_pkg::cmd_t head,
	output logic           empty
);

	gcst_pkg::cmd_t                slot_q [gcst_pkg::Q_DEPTH];
	logic [gcst_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [gcst_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [gcst_pkg::Q_PTR_W:0]   fill_q;

	assign full  = (fill_q == (gcst_pkg::Q_PTR_W+1)'(gcst_pkg::Q_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gcst_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gcst_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (gcst_pkg::Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (gcst_pkg::Q_PTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- sv/gcst_back.sv -----
// Table engine: color memory, load read path, stores, flip walk, reset clear.
`timescale 1ns / 1ps
module gcst_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  gcst_pkg::cmd_t               head,
	output logic                         pop,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gcst_pkg::COLOR_W-1:0] read_color
);

	logic [gcst_pkg::COLOR_W-1:0] mem [gcst_pkg::TABLE_DEPTH];
	logic [gcst_pkg::COLOR_W-1:0] rdata_q;

	logic                         clr_q;
	logic [gcst_pkg::IDX_W-1:0]   clr_ptr_q;

	logic                         ld_v_s1;
	logic                         ld_rng_s1;
	logic                         out_valid_q;
	logic [gcst_pkg::COLOR_W-1:0] out_color_q;

	logic                         flip_on_q;
	logic [gcst_pkg::USE_W-1:0]   flip_ptr_q;
	logic [gcst_pkg::USE_W-1:0]   flip_cnt_q;
	logic [gcst_pkg::COLOR_W-1:0] flip_color_q;
	logic [gcst_pkg::COLOR_W-1:0] flip_match_q;
	logic                         fw_v_s1;
	logic [gcst_pkg::IDX_W-1:0]   fw_idx_s1;

	logic                         busy;
	logic                         s1_adv;
	logic                         s1_free;
	logic                         pop_load;
	logic                         pop_store;
	logic                         pop_flip;
	logic                         rd_en;
	logic [gcst_pkg::IDX_W-1:0]   rd_addr;
	logic                         we;
	logic [gcst_pkg::IDX_W-1:0]   wa;
	logic [gcst_pkg::COLOR_W-1:0] wd;

	always_comb begin
		busy    = flip_on_q || fw_v_s1;
		s1_adv  = ld_v_s1 && (!out_valid_q || !out_stall);
		s1_free = !ld_v_s1 || s1_adv;
		pop     = 1'b0;
		if (!q_empty && !clr_q && !busy) begin
			unique case (head.op)
				gcst_pkg::OP_LOAD:  pop = s1_free;
				gcst_pkg::OP_STORE: pop = 1'b1;
				gcst_pkg::OP_FLIP:  pop = !ld_v_s1;
				gcst_pkg::OP_NOP:   pop = 1'b1;
				default:            pop = 1'b1;
			endcase
		end
		pop_load  = pop && (head.op == gcst_pkg::OP_LOAD);
		pop_store = pop && (head.op == gcst_pkg::OP_STORE);
		pop_flip  = pop && (head.op == gcst_pkg::OP_FLIP);

		rd_en   = pop_load || flip_on_q;
		rd_addr = flip_on_q ? flip_ptr_q[gcst_pkg::IDX_W-1:0] : head.idx;

		priority if (clr_q) begin
			we = 1'b1;
			wa = clr_ptr_q;
			wd = '0;
		end else if (fw_v_s1) begin
			we = (rdata_q == flip_match_q);
			wa = fw_idx_s1;
			wd = flip_color_q;
		end else begin
			we = pop_store && head.in_range;
			wa = head.idx;
			wd = head.color;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_ptr_q <= '0;
		end else if (clr_q) begin
			clr_ptr_q <= clr_ptr_q + gcst_pkg::IDX_W'(1);
			if (clr_ptr_q == gcst_pkg::IDX_W'(gcst_pkg::TABLE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// load path: read issued at pop, data lands in rdata_q, then output reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_load) begin
				ld_v_s1 <= 1'b1;
			end else if (s1_adv) begin
				ld_v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_load) begin
			ld_rng_s1 <= head.in_range;
		end
		if (s1_adv) begin
			out_color_q <= ld_rng_s1 ? rdata_q : '0;
		end
	end

	// flip walk: read entry i while writing back entry i-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_on_q <= 1'b0;
			fw_v_s1   <= 1'b0;
		end else begin
			fw_v_s1 <= flip_on_q;
			if (pop_flip && (head.count != '0)) begin
				flip_on_q <= 1'b1;
			end else if (flip_on_q && (flip_ptr_q + gcst_pkg::USE_W'(1) == flip_cnt_q)) begin
				flip_on_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_flip) begin
			flip_ptr_q   <= '0;
			flip_cnt_q   <= head.count;
			flip_color_q <= head.color;
			flip_match_q <= head.match;
		end else if (flip_on_q) begin
			flip_ptr_q <= flip_ptr_q + gcst_pkg::USE_W'(1);
		end
		fw_idx_s1 <= flip_ptr_q[gcst_pkg::IDX_W-1:0];
	end

	assign clearing   = clr_q;
	assign out_valid  = out_valid_q;
	assign read_color = out_color_q;

endmodule

// ----- sv/gc_color_side_table_top.sv -----
// Top level of the garbage-collector color side table.
// One 8-bit color per 4 KiB heap granule, 4096 entries. After reset the block
// runs a clearing pass that sets every entry to 0 and holds in_stall high
// meanwhile; configuration writes are taken at any time. Loads and stores are
// accepted one per cycle while in_stall is low through a four-item command
// queue; a load result passes through the memory read register, then the
// output register, after the command leaves the queue. A flip occupies the
// table engine with one read and one write-back per entry, reads overlapping
// write-backs; the queue keeps taking items until it fills.
`timescale 1ns / 1ps
module gc_color_side_table_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [gcst_pkg::ADDR_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   operation,
	input  logic [gcst_pkg::ADDR_W-1:0]  address,
	input  logic [gcst_pkg::COLOR_W-1:0] color,
	input  logic [gcst_pkg::COLOR_W-1:0] match_color,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gcst_pkg::COLOR_W-1:0] read_color
);

	logic [gcst_pkg::ADDR_W-1:0]    heap_base_q;
	logic [gcst_pkg::CFG_CNT_W-1:0] entry_count_q;
	logic                           keep;
	gcst_pkg::cmd_t                 cmd;
	gcst_pkg::cmd_t                 head;
	logic                           q_full;
	logic                           q_empty;
	logic                           pop;
	logic                           clearing;
	logic                           push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= '0;
			entry_count_q <= gcst_pkg::ENTRY_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcst_pkg::REG_HEAP_BASE:   heap_base_q <= cfg_data;
				gcst_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[gcst_pkg::CFG_CNT_W-1:0];
				default:                   heap_base_q <= heap_base_q;
			endcase
		end
	end

	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall && keep;

	gcst_front u_front (
		.operation   (operation),
		.address     (address),
		.color       (color),
		.match_color (match_color),
		.heap_base   (heap_base_q),
		.entry_count (entry_count_q),
		.keep        (keep),
		.cmd         (cmd)
	);

	gcst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	gcst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_color (read_color)
	);

endmodule

// ----- dv/gc_color_side_table_top_test.sv -----
// Self-checking testbench for the garbage-collector color side table top level.
`timescale 1ns / 1ps
module gc_color_side_table_top_test;

	localparam int ADDR_W        = gcst_pkg::ADDR_W;
	localparam int COLOR_W       = gcst_pkg::COLOR_W;
	localparam int CFG_CNT_W     = gcst_pkg::CFG_CNT_W;
	localparam int GRANULE_SHIFT = gcst_pkg::GRANULE_SHIFT;
	localparam int TABLE_DEPTH   = gcst_pkg::TABLE_DEPTH;
	localparam int IDX_W         = gcst_pkg::IDX_W;
	localparam int OFF_W         = gcst_pkg::OFF_W;
	localparam int Q_DEPTH       = gcst_pkg::Q_DEPTH;

	localparam logic [1:0] OP_LOAD  = gcst_pkg::OP_LOAD;
	localparam logic [1:0] OP_STORE = gcst_pkg::OP_STORE;
	localparam logic [1:0] OP_FLIP  = gcst_pkg::OP_FLIP;
	localparam logic [1:0] OP_NOP   = gcst_pkg::OP_NOP;

	localparam logic REG_HEAP_BASE   = gcst_pkg::REG_HEAP_BASE;
	localparam logic REG_ENTRY_COUNT = gcst_pkg::REG_ENTRY_COUNT;

	localparam logic [CFG_CNT_W-1:0] ENTRY_COUNT_RESET = gcst_pkg::ENTRY_COUNT_RESET;

	localparam int unsigned SETTLE_CYCLES = (Q_DEPTH + 2) * (TABLE_DEPTH + 2);
	localparam int unsigned CYCLE_LIMIT   = 1_200_000;
	localparam int unsigned GRANULE_BYTES = 1 << GRANULE_SHIFT;

	typedef struct packed {
		logic [1:0]         op;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic [COLOR_W-1:0] match;
	} gc_req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_HEAP_BASE;
	logic [ADDR_W-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = OP_NOP;
	logic [ADDR_W-1:0]  address = '0;
	logic [COLOR_W-1:0] color = '0;
	logic [COLOR_W-1:0] match_color = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COLOR_W-1:0] read_color;

	// shadow copy of the table and its registers
	logic [COLOR_W-1:0]   shadow_table [TABLE_DEPTH];
	logic [ADDR_W-1:0]    shadow_base = '0;
	logic [CFG_CNT_W-1:0] shadow_count = ENTRY_COUNT_RESET;

	gc_req_t             pending_reqs [$];
	logic [COLOR_W-1:0]  colors_due [$];
	logic [ADDR_W-1:0]   recent_addr [$];

	gc_req_t     cur_req = '0;
	bit          sending = 1'b0;
	int unsigned send_gap = 0;
	int unsigned hold_left = 0;
	bit          sender_calm = 1'b0;
	bit          receiver_calm = 1'b0;
	logic        choke = 1'b0;
	int          phase_idx = -1;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	gc_color_side_table_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.address     (address),
		.color       (color),
		.match_color (match_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_color  (read_color)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned granules_in_use();
		return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
	endfunction

	function automatic bit locate_granule(input logic [ADDR_W-1:0] a,
			output logic [IDX_W-1:0] slot);
		logic [ADDR_W-1:0] delta;
		logic [OFF_W-1:0]  idx;
		slot = '0;
		if (a < shadow_base)
			return 1'b0;
		delta = a - shadow_base;
		idx = delta[ADDR_W-1:GRANULE_SHIFT];
		if (idx >= OFF_W'(granules_in_use()))
			return 1'b0;
		slot = idx[IDX_W-1:0];
		return 1'b1;
	endfunction

	task automatic predict_table_op(input gc_req_t r);
		logic [IDX_W-1:0] slot;
		bit               hit;
		int unsigned      used;
		used = granules_in_use();
		hit = locate_granule(r.addr, slot);
		case (r.op)
			OP_LOAD: begin
				colors_due.push_back(hit ? shadow_table[slot] : '0);
			end
			OP_STORE: begin
				if (hit)
					shadow_table[slot] = r.color;
			end
			OP_FLIP: begin
				for (int i = 0; i < used; i++)
					if (shadow_table[i] == r.match)
						shadow_table[i] = r.color;
			end
			default: ;
		endcase
	endtask

	function automatic int unsigned draw_wait(input bit calm);
		if (calm)
			return 0;
		return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 17) : 0;
	endfunction

	function automatic logic [ADDR_W-1:0] any_address();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		if ($urandom_range(0, 2) == 0)
			return COLOR_W'($urandom_range(0, 255));
		return COLOR_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [ADDR_W-1:0] granule_address(input int unsigned idx);
		return shadow_base + (ADDR_W'(idx) << GRANULE_SHIFT)
			+ ADDR_W'($urandom_range(0, GRANULE_BYTES - 1));
	endfunction

	// mostly addresses that land in the table, the rest near its edges or anywhere
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned k;
		int unsigned used;
		used = granules_in_use();
		k = $urandom_range(0, 19);
		if (k < 6 && recent_addr.size() != 0)
			return recent_addr[$urandom_range(0, recent_addr.size() - 1)];
		if (k < 14 && used != 0)
			return granule_address($urandom_range(0, used - 1));
		if (k < 16)
			return granule_address(used + $urandom_range(0, 3));
		if (k < 18 && shadow_base != 0)
			return shadow_base - ADDR_W'($urandom_range(1, 2 * GRANULE_BYTES));
		return any_address();
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [ADDR_W-1:0] a,
			input logic [COLOR_W-1:0] c, input logic [COLOR_W-1:0] m);
		gc_req_t r;
		r = '{op: op, addr: a, color: c, match: m};
		pending_reqs.push_back(r);
		if (op == OP_STORE) begin
			recent_addr.push_back(a);
			if (recent_addr.size() > 8)
				void'(recent_addr.pop_front());
		end
	endtask

	task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEAP_BASE)
			shadow_base = val;
		else
			shadow_count = val[CFG_CNT_W-1:0];
	endtask

	task automatic begin_phase(input int n, input logic [ADDR_W-1:0] base,
			input logic [CFG_CNT_W-1:0] count, input bit calm);
		write_reg(REG_HEAP_BASE, base);
		write_reg(REG_ENTRY_COUNT, ADDR_W'(count));
		sender_calm = calm;
		receiver_calm = calm;
		recent_addr.delete();
		phase_idx = n;
	endtask

	// stores and flips leave no result, so give the block time to finish them
	task automatic drain_phase();
		while (pending_reqs.size() != 0 || sending || colors_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input logic [ADDR_W-1:0] base,
			input logic [CFG_CNT_W-1:0] count, input bit calm, input int items);
		int          made;
		int unsigned k;
		logic [1:0]  op;
		begin_phase(n, base, count, calm);
		made = 0;
		while (made < items) begin
			k = $urandom_range(0, 99);
			if (k < 52)
				op = OP_LOAD;
			else if (k < 90)
				op = OP_STORE;
			else if (k < 93)
				op = OP_FLIP;
			else
				op = OP_NOP;
			if (op != OP_NOP)
				made++;
			add_req(op, pick_address(), pick_color(), pick_color());
		end
		drain_phase();
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sending = 1'b0;
			send_gap = 0;
		end else begin
			if (sending && !in_stall) begin
				predict_table_op(cur_req);
				sending = 1'b0;
				send_gap = draw_wait(sender_calm);
			end
			if (!sending) begin
				if (send_gap != 0)
					send_gap--;
				else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					sending = 1'b1;
				end
			end
			in_valid <= sending;
			operation <= cur_req.op;
			address <= cur_req.addr;
			color <= cur_req.color;
			match_color <= cur_req.match;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (colors_due.size() == 0) begin
					$display("%0t: read_color expected none got %02h", $time, read_color);
					mismatches++;
				end else if (read_color !== colors_due[0]) begin
					$display("%0t: read_color expected %02h got %02h", $time,
						colors_due[0], read_color);
					mismatches++;
				end
				if (colors_due.size() != 0)
					void'(colors_due.pop_front());
				hold_left = draw_wait(receiver_calm);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= choke || hold_left != 0;
		end
	end

	// long hold-off on the result side while items keep coming
	initial begin
		wait (phase_idx == 1);
		repeat (24) @(posedge clk);
		choke <= 1'b1;
		repeat (400) @(posedge clk);
		choke <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] g;
		foreach (shadow_table[i])
			shadow_table[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		b = ADDR_W'(48'h0000_0010_0000);
		g = ADDR_W'(GRANULE_BYTES);
		begin_phase(0, b, ENTRY_COUNT_RESET, 1'b0);
		add_req(OP_LOAD, b, 8'h00, 8'h00);
		add_req(OP_STORE, b + g - 1, 8'hFF, 8'h00);
		add_req(OP_LOAD, b, 8'h00, 8'h00);
		add_req(OP_STORE, b + 4095 * g + g - 1, 8'h01, 8'h00);
		add_req(OP_LOAD, b + 4095 * g, 8'h00, 8'h00);
		add_req(OP_STORE, b + 4096 * g, 8'hAA, 8'h00);
		add_req(OP_LOAD, b + 4096 * g, 8'h00, 8'h00);
		add_req(OP_LOAD, '0, 8'h00, 8'h00);
		add_req(OP_STORE, '0, 8'h55, 8'h00);
		add_req(OP_LOAD, b - 1, 8'h00, 8'h00);
		add_req(OP_STORE, '1, 8'h77, 8'h00);
		add_req(OP_LOAD, '1, 8'h00, 8'h00);
		add_req(OP_FLIP, '0, 8'h5A, 8'hFF);
		add_req(OP_LOAD, b + 10, 8'h00, 8'h00);
		add_req(OP_FLIP, '0, 8'h5A, 8'h5A);
		add_req(OP_LOAD, b, 8'h00, 8'h00);
		add_req(OP_NOP, b, 8'hFF, 8'hFF);
		add_req(OP_LOAD, b, 8'h00, 8'h00);
		add_req(OP_FLIP, '1, 8'h80, 8'h00);
		add_req(OP_LOAD, b + 7 * g, 8'h00, 8'h00);
		add_req(OP_LOAD, b + 4095 * g, 8'h00, 8'h00);
		add_req(OP_STORE, b + 5 * g, 8'h00, 8'hFF);
		add_req(OP_LOAD, b + 5 * g, 8'h00, 8'h00);
		drain_phase();

		random_phase(1, any_address(), CFG_CNT_W'(16), 1'b1, 120);
		random_phase(2, any_address(), '0, 1'b0, 40);
		random_phase(3, '1, '1, 1'b0, 40);
		random_phase(4, any_address() & ~ADDR_W'(GRANULE_BYTES - 1), '1, 1'b0, 110);
		random_phase(5, any_address(), CFG_CNT_W'($urandom_range(1, 64)), 1'b0, 130);
		random_phase(6, '0, ENTRY_COUNT_RESET, 1'b0, 110);
		random_phase(7, any_address(), CFG_CNT_W'(TABLE_DEPTH + 1), 1'b0, 100);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/gcst_pkg.sv
sv/gcst_front.sv
sv/gcst_fifo.sv
sv/gcst_back.sv
sv/gc_color_side_table_top.sv
dv/gc_color_side_table_top_test.sv
